// ===== hdl/sparse_frame_dirty_rows_core_assert.svh =====
// Assertion macros for the sparse frame dirty-row detector.
// Used by the top level; no other dependencies.
`ifndef SPARSE_FRAME_DIRTY_ROWS_CORE_ASSERT_SVH
`define SPARSE_FRAME_DIRTY_ROWS_CORE_ASSERT_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge out of reset
`define SFDR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("sfdr invariant violated");

// Check that a trigger implies a condition in the same cycle
`define SFDR_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("sfdr same-cycle check failed");

// Check that a trigger implies a condition in the next cycle
`define SFDR_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("sfdr next-cycle check failed");

`else

`define SFDR_ASSERT_ALWAYS(lbl, cond)
`define SFDR_ASSERT_NOW(lbl, trig, cond)
`define SFDR_ASSERT_NEXT(lbl, trig, cond)

`endif

`endif

// ===== hdl/sfdr_pkg.sv =====
// Shared types, constants and helper functions of the dirty-row detector.
// No dependencies; used by all modules of the block.
package sfdr_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int PIXEL_BITS = 32;
    localparam int DIM_W      = 12;   // row / column index width
    localparam int CFG_W      = 13;   // width / height register width
    localparam int SHIFT_W    = 6;
    localparam int SLIP_W     = 3;
    localparam int DIFF_W     = 15;   // row*slip + shift + bias - column

    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 32;

    // Common multiple of every step, keeps the phase difference non-negative
    localparam logic [DIFF_W-1:0] SAMPLE_BIAS = 15'd4200;

    // Height band limits
    localparam logic [CFG_W-1:0] BAND_LIM_0 = 13'd540;
    localparam logic [CFG_W-1:0] BAND_LIM_1 = 13'd720;
    localparam logic [CFG_W-1:0] BAND_LIM_2 = 13'd1080;
    localparam logic [CFG_W-1:0] BAND_LIM_3 = 13'd1440;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1080;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Inverses modulo 2^15 (and 2^12 for the factor 3 of 24) for divisibility
    localparam logic [DIFF_W-1:0] INV3_15  = 15'd10923;
    localparam logic [DIFF_W-1:0] INV15_15 = 15'd28399;
    localparam logic [DIFF_W-1:0] INV35_15 = 15'd12171;
    localparam logic [11:0]       INV3_12  = 12'd2731;
    localparam logic [DIFF_W-1:0] LIM3_15  = 15'd10922;
    localparam logic [DIFF_W-1:0] LIM15_15 = 15'd2184;
    localparam logic [DIFF_W-1:0] LIM35_15 = 15'd936;
    localparam logic [11:0]       LIM3_12  = 12'd1365;

    typedef enum logic [2:0] {
        BAND_SLIP2 = 3'd0,
        BAND_SLIP3 = 3'd1,
        BAND_SLIP4 = 3'd2,
        BAND_SLIP5 = 3'd3,
        BAND_SLIP6 = 3'd4
    } t_band;

    // One classified pixel handed from front to back
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic             hit;
        logic             frame_end;
    } t_cls;

    // Queue status seen by the front and the top level
    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    function automatic t_band band_for(input logic [CFG_W-1:0] h);
        t_band b;
        if (h < BAND_LIM_0)      b = BAND_SLIP2;
        else if (h < BAND_LIM_1) b = BAND_SLIP3;
        else if (h < BAND_LIM_2) b = BAND_SLIP4;
        else if (h < BAND_LIM_3) b = BAND_SLIP5;
        else                     b = BAND_SLIP6;
        return b;
    endfunction

    function automatic logic [SLIP_W-1:0] slip_of(input t_band b);
        logic [SLIP_W-1:0] s;
        case (b)
            BAND_SLIP2: s = 3'd2;
            BAND_SLIP3: s = 3'd3;
            BAND_SLIP4: s = 3'd4;
            BAND_SLIP5: s = 3'd5;
            BAND_SLIP6: s = 3'd6;
            default:    s = 3'd6;
        endcase
        return s;
    endfunction

    // True when d is a multiple of the band's step (slip*slip-1).
    // Odd steps use the modular-inverse test; 8 and 24 check the low bits first.
    function automatic logic step_hit(input t_band b, input logic [DIFF_W-1:0] d);
        logic [2*DIFF_W-1:0] p;
        logic [23:0]         q;
        logic                h;
        p = '0;
        q = '0;
        case (b)
            BAND_SLIP2: begin
                p = (2*DIFF_W)'(d) * (2*DIFF_W)'(INV3_15);
                h = (p[DIFF_W-1:0] <= LIM3_15);
            end
            BAND_SLIP3: begin
                h = (d[2:0] == 3'd0);
            end
            BAND_SLIP4: begin
                p = (2*DIFF_W)'(d) * (2*DIFF_W)'(INV15_15);
                h = (p[DIFF_W-1:0] <= LIM15_15);
            end
            BAND_SLIP5: begin
                q = 24'(d[DIFF_W-1:3]) * 24'(INV3_12);
                h = (d[2:0] == 3'd0) && (q[11:0] <= LIM3_12);
            end
            BAND_SLIP6: begin
                p = (2*DIFF_W)'(d) * (2*DIFF_W)'(INV35_15);
                h = (p[DIFF_W-1:0] <= LIM35_15);
            end
            default: h = 1'b0;
        endcase
        return h;
    endfunction

endpackage

// ===== hdl/sfdr_front.sv =====
// Front part: accepts pixel pairs, works out the sampling match and the
// pixel difference over two stages, and pushes classified items. Uses sfdr_pkg.
module sfdr_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [sfdr_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 i_s_tlast,
    input  logic [sfdr_pkg::CFG_W-1:0]           i_frame_width,
    input  logic [sfdr_pkg::CFG_W-1:0]           i_frame_height,
    input  sfdr_pkg::t_q_stat                    i_q_stat,
    output logic                                 o_push,
    output sfdr_pkg::t_cls                       o_item
);

    logic [sfdr_pkg::PIXEL_BITS-1:0] w_old;
    logic [sfdr_pkg::PIXEL_BITS-1:0] w_new;
    logic [sfdr_pkg::DIM_W-1:0]      w_col;
    logic [sfdr_pkg::DIM_W-1:0]      w_row;
    logic [sfdr_pkg::SHIFT_W-1:0]    w_shift;
    sfdr_pkg::t_band                 w_band;
    logic [sfdr_pkg::DIFF_W-1:0]     w_diff;
    logic                            w_adv1;
    logic                            w_adv2;

    // Stage 1 registers
    logic                            r_v1;
    sfdr_pkg::t_band                 r_band1;
    logic [sfdr_pkg::DIFF_W-1:0]     r_diff1;
    logic                            r_inb1;
    logic                            r_ne1;
    logic [sfdr_pkg::DIM_W-1:0]      r_row1;
    logic                            r_last1;

    // Stage 2 registers
    logic                            r_v2;
    sfdr_pkg::t_cls                  r_item2;

    // Unpack the input transfer
    assign w_old   = i_s_tdata[31:0];
    assign w_new   = i_s_tdata[63:32];
    assign w_col   = i_s_tdata[75:64];
    assign w_row   = i_s_tdata[87:76];
    assign w_shift = i_s_tdata[93:88];

    // Phase difference: row*slip + shift - column, biased by a common multiple
    assign w_band = sfdr_pkg::band_for(i_frame_height);
    assign w_diff = sfdr_pkg::DIFF_W'(w_row) * sfdr_pkg::DIFF_W'(sfdr_pkg::slip_of(w_band))
                  + sfdr_pkg::DIFF_W'(w_shift) + sfdr_pkg::SAMPLE_BIAS
                  - sfdr_pkg::DIFF_W'(w_col);

    // Advance each stage when the one after it has room
    assign w_adv2     = !r_v2 || !i_q_stat.full;
    assign w_adv1     = !r_v1 || w_adv2;
    assign o_s_tready = w_adv1;
    assign o_push     = r_v2 && !i_q_stat.full;
    assign o_item     = r_item2;

    // Stage 1: capture difference, bounds and pixel compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= i_s_tvalid;
        end
        if (w_adv1) begin
            r_band1 <= w_band;
            r_diff1 <= w_diff;
            r_inb1  <= ({1'b0, w_row} < i_frame_height) && ({1'b0, w_col} < i_frame_width);
            r_ne1   <= (w_old != w_new);
            r_row1  <= w_row;
            r_last1 <= i_s_tlast;
        end
    end

    // Stage 2: divisibility test, form the classified item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
        if (w_adv2) begin
            r_item2.row       <= r_row1;
            r_item2.hit       <= r_inb1 && r_ne1 && sfdr_pkg::step_hit(r_band1, r_diff1);
            r_item2.frame_end <= r_last1;
        end
    end

endmodule

// ===== hdl/sfdr_queue.sv =====
// Short queue of classified items between front and back parts.
// Uses sfdr_pkg for the item type and depth.
module sfdr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfdr_pkg::t_cls     i_item,
    input  logic               i_pop,
    output logic               o_valid,
    output sfdr_pkg::t_cls     o_item,
    output sfdr_pkg::t_q_stat  o_stat
);

    sfdr_pkg::t_cls                  r_mem [sfdr_pkg::QDEPTH];
    logic [sfdr_pkg::QPTR_W-1:0]     r_wr;
    logic [sfdr_pkg::QPTR_W-1:0]     r_rd;
    logic [sfdr_pkg::QCNT_W-1:0]     r_count;
    logic                            w_do_pop;

    assign o_valid     = (r_count != '0);
    assign o_item      = r_mem[r_rd];
    assign o_stat.full = (r_count == sfdr_pkg::QCNT_W'(sfdr_pkg::QDEPTH));
    assign o_stat.count = r_count;
    assign w_do_pop    = i_pop && o_valid;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/sfdr_back.sv =====
// Back part: tracks per-row hits, the dirty flag and the row range, and
// holds the end-of-frame result in an output register. Uses sfdr_pkg.
module sfdr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  sfdr_pkg::t_cls                  i_item,
    output logic                            o_pop,
    input  logic [sfdr_pkg::CFG_W-1:0]      i_frame_height,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sfdr_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    logic                            r_dirty;
    logic [sfdr_pkg::DIM_W-1:0]      r_low;
    logic [sfdr_pkg::CFG_W-1:0]      r_high;
    logic                            r_row_done;
    logic [sfdr_pkg::DIM_W-1:0]      r_last_row;
    logic                            r_out_valid;
    logic                            r_out_changed;
    logic [sfdr_pkg::DIM_W-1:0]      r_out_first;
    logic [sfdr_pkg::DIM_W-1:0]      r_out_last;

    logic                            n_dirty;
    logic [sfdr_pkg::DIM_W-1:0]      n_low;
    logic [sfdr_pkg::CFG_W-1:0]      n_high;
    logic                            n_row_done;

    logic [sfdr_pkg::SLIP_W-1:0]     w_slip;
    logic                            w_done_eff;
    logic                            w_take;
    logic [sfdr_pkg::CFG_W-1:0]      w_row_hi;
    logic [sfdr_pkg::CFG_W-1:0]      w_hmax;
    logic [sfdr_pkg::CFG_W-1:0]      w_hclip;
    logic                            w_out_free;

    assign w_slip     = sfdr_pkg::slip_of(sfdr_pkg::band_for(i_frame_height));
    assign w_out_free = !r_out_valid || i_m_tready;
    // Hold a frame end while the previous result still waits
    assign o_pop      = i_valid && (!i_item.frame_end || w_out_free);

    // Row hit tracking and range update for the popped item
    always_comb begin
        w_done_eff = (i_item.row != r_last_row) ? 1'b0 : r_row_done;
        w_take     = i_item.hit && !w_done_eff;
        w_row_hi   = {1'b0, i_item.row} + sfdr_pkg::CFG_W'(w_slip);
        n_row_done = w_take ? 1'b1 : w_done_eff;
        n_dirty    = r_dirty;
        n_low      = r_low;
        n_high     = r_high;
        if (w_take) begin
            n_dirty = 1'b1;
            if (!r_dirty) begin
                n_low = (i_item.row > sfdr_pkg::DIM_W'(w_slip))
                      ? i_item.row - sfdr_pkg::DIM_W'(w_slip) : '0;
            end
            if (w_row_hi > r_high) begin
                n_high = w_row_hi;
            end
        end
        // Clamp to the frame and to the largest index
        w_hmax = n_high;
        if (i_frame_height != '0 && w_hmax > i_frame_height - 1'b1) begin
            w_hmax = i_frame_height - 1'b1;
        end
        w_hclip = w_hmax;
        if (w_hmax > sfdr_pkg::CFG_W'(sfdr_pkg::MAX_DIM - 1)) begin
            w_hclip = sfdr_pkg::CFG_W'(sfdr_pkg::MAX_DIM - 1);
        end
    end

    // Frame state: restart after a frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty    <= 1'b0;
            r_low      <= '0;
            r_high     <= '0;
            r_row_done <= 1'b0;
            r_last_row <= '0;
        end else if (o_pop) begin
            if (i_item.frame_end) begin
                r_dirty    <= 1'b0;
                r_low      <= '0;
                r_high     <= '0;
                r_row_done <= 1'b0;
                r_last_row <= '0;
            end else begin
                r_dirty    <= n_dirty;
                r_low      <= n_low;
                r_high     <= n_high;
                r_row_done <= n_row_done;
                r_last_row <= i_item.row;
            end
        end
    end

    // Output register: load on frame end, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (o_pop && i_item.frame_end) begin
            r_out_changed <= n_dirty;
            r_out_first   <= n_dirty ? n_low : '0;
            r_out_last    <= n_dirty ? w_hclip[sfdr_pkg::DIM_W-1:0] : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_last, r_out_first, r_out_changed};

endmodule

// ===== hdl/sparse_frame_dirty_rows_core.sv =====
// Top level of the sparse frame dirty-row detector: configuration registers,
// front, queue and back. Uses sfdr_pkg, sfdr_front, sfdr_queue, sfdr_back.
//
// Takes one pixel pair per clock, sustained, and reports once per frame on
// the transfer marked last: the dirty flag and the refresh row range. Each
// pixel passes two front stages (bounds, phase arithmetic, then the
// divisibility test of the sampling phase), a four-entry queue, and a
// registered state update in the back part; o_m_tvalid comes from an output
// register loaded when the back part pops the frame's last item. The back
// update takes one item per clock and sets the rate; input stalls only when a
// frame result waits in the output register and the queue fills behind it.
`include "sparse_frame_dirty_rows_core_assert.svh"

module sparse_frame_dirty_rows_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input pixel stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata, low bit up: old_pixel[31:0], new_pixel[63:32], column[75:64],
    // row[87:76], phase_shift[93:88], zero pad[95:94]
    input  logic [sfdr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tlast,   // frame_end
    // Frame result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata, low bit up: changed[0], first_row[12:1], last_row[24:13],
    // zero pad[31:25]
    output logic [sfdr_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // Configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [sfdr_pkg::CFG_W-1:0]      i_cfg_data
);

    logic [sfdr_pkg::CFG_W-1:0] r_frame_width;
    logic [sfdr_pkg::CFG_W-1:0] r_frame_height;

    logic                       w_push;
    sfdr_pkg::t_cls             w_front_item;
    sfdr_pkg::t_q_stat          w_q_stat;
    logic                       w_q_valid;
    sfdr_pkg::t_cls             w_q_item;
    logic                       w_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= sfdr_pkg::WIDTH_RST;
            r_frame_height <= sfdr_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfdr_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                sfdr_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfdr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_item         (w_front_item)
    );

    sfdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    sfdr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .i_frame_height (r_frame_height),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_m_tdata      (o_m_tdata)
    );

    // Queue never overfills
    `SFDR_ASSERT_ALWAYS(a_queue_bound, w_q_stat.count <= sfdr_pkg::QCNT_W'(sfdr_pkg::QDEPTH))
    // A full queue takes no push
    `SFDR_ASSERT_NOW(a_no_push_full, w_q_stat.full, !w_push)
    // A clean frame reports an empty range
    `SFDR_ASSERT_NOW(a_clean_zero, o_m_tvalid && !o_m_tdata[0], o_m_tdata[24:1] == 24'd0)
    // A dirty range is never inverted
    `SFDR_ASSERT_NOW(a_range_order, o_m_tvalid && o_m_tdata[0], o_m_tdata[12:1] <= o_m_tdata[24:13])

endmodule
